// File: design/clp_pkg.sv
`default_nettype none

package clp_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_NO_TERM  = 2'd2;
	localparam logic [1:0] ST_TOO_MANY = 2'd3;

	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_END   = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	// carriage returns never reach the queue
	typedef enum logic [1:0] {
		CLS_NL,
		CLS_SP,
		CLS_DIG,
		CLS_OTH
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] data;
	} ent_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  code;
		logic [2:0]  idx;
		logic [15:0] value;
		logic [3:0]  total;
		logic [5:0]  chars;
		logic [1:0]  status;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// File: design/clp_front.sv
`default_nettype none

module clp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    byte_in,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               q_push,
	output clp_pkg::ent_t      q_data,
	input  wire logic          q_full
);
	import clp_pkg::*;

	logic v_s1;
	ent_t ent_s1;
	ent_t ent_c;
	logic is_cr;

	always_comb begin
		ent_c.data = byte_in;
		is_cr      = (byte_in == CH_CR);
		if (byte_in == CH_NL) begin
			ent_c.cls = CLS_NL;
		end else if (byte_in == CH_SPACE) begin
			ent_c.cls = CLS_SP;
		end else if (byte_in >= CH_ZERO && byte_in <= CH_NINE) begin
			ent_c.cls = CLS_DIG;
		end else begin
			ent_c.cls = CLS_OTH;
		end
	end

	assign in_stall = v_s1 && q_full;
	assign q_push   = v_s1 && !q_full;
	assign q_data   = ent_s1;

	// drop carriage returns here: they change nothing downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid && !is_cr;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ent_s1 <= ent_c;
		end
	end

endmodule

`default_nettype wire

// File: design/clp_queue.sv
`default_nettype none

module clp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire clp_pkg::ent_t wr_data,
	output logic               full,
	input  wire logic          pop,
	output logic               rd_valid,
	output clp_pkg::ent_t      rd_data
);
	import clp_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	ent_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/clp_back.sv
`default_nettype none

module clp_back #(
	parameter int MAX_LINE   = 64,
	parameter int MAX_PARAMS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_valid,
	input  wire clp_pkg::ent_t rd_data,
	output logic               pop,
	output logic               out_valid,
	output clp_pkg::res_t      out_res,
	input  wire logic          out_stall
);
	import clp_pkg::*;

	localparam int LW = $clog2(MAX_LINE);
	localparam int PW = $clog2(MAX_PARAMS + 1);

	logic [LW-1:0] pos_q,   pos_n;
	logic          innum_q, innum_n;
	logic [15:0]   acc_q,   acc_n;
	logic [PW-1:0] cnt_q,   cnt_n;
	logic [7:0]    code_q,  code_n;
	logic          disc_q,  disc_n;

	logic          out_v_q;
	res_t          out_res_q;
	logic          pend_q;
	res_t          pend_res_q;

	logic          can_load;
	logic          take;
	logic          emit;
	logic          two;
	res_t          res_c;
	res_t          pend_c;
	logic [LW-1:0] pos_inc;
	logic [15:0]   digit;

	function automatic res_t mk_param(input logic [7:0] code, input logic [PW-1:0] idx,
			input logic [15:0] value, input logic last);
		res_t r;
		r        = '0;
		r.kind   = KIND_PARAM;
		r.code   = code;
		r.idx    = 3'(idx);
		r.value  = value;
		r.last   = last;
		return r;
	endfunction

	function automatic res_t mk_end(input logic [7:0] code, input logic [PW-1:0] tot,
			input logic [LW-1:0] chars, input logic [1:0] status);
		res_t r;
		r        = '0;
		r.kind   = KIND_END;
		r.code   = code;
		r.total  = 4'(tot);
		r.chars  = 6'(chars);
		r.status = status;
		r.last   = 1'b1;
		return r;
	endfunction

	assign can_load  = !out_v_q || !out_stall;
	assign take      = rd_valid && can_load && !pend_q;
	assign pop       = take;
	assign out_valid = out_v_q;
	assign out_res   = out_res_q;
	assign pos_inc   = pos_q + LW'(1);
	assign digit     = {12'd0, rd_data.data[3:0]};

	always_comb begin
		pos_n   = pos_q;
		innum_n = innum_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		code_n  = code_q;
		disc_n  = disc_q;
		emit    = 1'b0;
		two     = 1'b0;
		res_c   = '0;
		pend_c  = '0;
		if (take) begin
			if (rd_data.cls == CLS_NL) begin
				if (!disc_q) begin
					emit = 1'b1;
					if (innum_q) begin
						// number then end of command; the end result waits in the pending register
						two    = 1'b1;
						res_c  = mk_param(code_q, cnt_q, acc_q, 1'b0);
						pend_c = mk_end(code_q, cnt_q + PW'(1), pos_q, ST_OK);
					end else begin
						res_c = mk_end(code_q, cnt_q, pos_q, ST_OK);
					end
				end
				pos_n   = '0;
				innum_n = 1'b0;
				acc_n   = '0;
				cnt_n   = '0;
				code_n  = '0;
				disc_n  = 1'b0;
			end else if (disc_q) begin
				emit = 1'b0;
			end else if (pos_q == LW'(MAX_LINE - 1)) begin
				emit   = 1'b1;
				res_c  = mk_end(code_q, cnt_q, pos_q, ST_NO_TERM);
				disc_n = 1'b1;
			end else if (pos_q == '0) begin
				code_n = rd_data.data;
				pos_n  = LW'(1);
			end else begin
				pos_n = pos_inc;
				unique case (rd_data.cls)
					CLS_SP: begin
						if (innum_q) begin
							emit    = 1'b1;
							res_c   = mk_param(code_q, cnt_q, acc_q, 1'b1);
							cnt_n   = cnt_q + PW'(1);
							acc_n   = '0;
							innum_n = 1'b0;
						end
					end
					CLS_DIG: begin
						if (!innum_q && cnt_q >= PW'(MAX_PARAMS)) begin
							emit   = 1'b1;
							res_c  = mk_end(code_q, cnt_q, pos_inc, ST_TOO_MANY);
							disc_n = 1'b1;
						end else begin
							acc_n   = (acc_q << 3) + (acc_q << 1) + digit;
							innum_n = 1'b1;
						end
					end
					default: begin
						emit   = 1'b1;
						res_c  = mk_end(code_q, cnt_q, pos_inc, ST_BAD_CHAR);
						disc_n = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			innum_q <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
			code_q  <= '0;
			disc_q  <= 1'b0;
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			pos_q   <= pos_n;
			innum_q <= innum_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			code_q  <= code_n;
			disc_q  <= disc_n;
			if (can_load) begin
				out_v_q <= pend_q || (take && emit);
				pend_q  <= !pend_q && take && two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			out_res_q <= pend_q ? pend_res_q : res_c;
		end
		if (take && two) begin
			pend_res_q <= pend_c;
		end
	end

endmodule

`default_nettype wire

// File: design/command_line_decimal_parser_core.sv
// Each byte is registered in the classifier, passes the queue and is registered again
// at the parser output. Throughput: one byte per cycle while no stall holds the flow;
// a newline that closes a number gives two results, the four-entry queue absorbs them.
// Reset: arst_n clears the queue, the output register and all line state at once;
// the parser then waits for the command code of a new line.
`default_nettype none

module command_line_decimal_parser_core #(
	parameter int MAX_LINE   = 64,
	parameter int MAX_PARAMS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [7:0]       command_code,
	output logic [2:0]       param_index,
	output logic [15:0]      param_value,
	output logic [3:0]       param_total,
	output logic [5:0]       char_count,
	output logic [1:0]       status,
	output logic             last
);
	import clp_pkg::*;

	logic q_push;
	ent_t q_wdata;
	logic q_full;
	logic q_pop;
	logic q_valid;
	ent_t q_rdata;
	res_t res;

	clp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	clp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rdata)
	);

	clp_back #(
		.MAX_LINE   (MAX_LINE),
		.MAX_PARAMS (MAX_PARAMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (q_valid),
		.rd_data   (q_rdata),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_res   (res),
		.out_stall (out_stall)
	);

	assign result_kind  = res.kind;
	assign command_code = res.code;
	assign param_index  = res.idx;
	assign param_value  = res.value;
	assign param_total  = res.total;
	assign char_count   = res.chars;
	assign status       = res.status;
	assign last         = res.last;

`ifndef SYNTH
	// a parameter that is not last must be followed straight away by its end result
	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_kind == KIND_PARAM && !last
		|=> out_valid && result_kind == KIND_END)
		else $error("end of command did not follow closing parameter");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_END |-> last)
		else $error("end of command not marked last");

	a_param_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PARAM
		|-> param_total == 4'd0 && char_count == 6'd0 && status == ST_OK)
		else $error("parameter result carries end fields");
`endif

endmodule

`default_nettype wire

// File: sim/command_line_decimal_parser_core_tb.sv
`timescale 1ns / 100ps

import clp_pkg::*;

class line_scoreboard #(int LINE_MAX = 64, int PARAM_MAX = 8);

	int          line_len;
	bit          in_number;
	logic [15:0] acc;
	int          params_done;
	logic [7:0]  code;
	bit          dropping;
	res_t        awaited_results[$];
	int          failures;

	function void start_line();
		line_len    = 0;
		in_number   = 0;
		acc         = '0;
		params_done = 0;
		code        = '0;
		dropping    = 0;
	endfunction

	function new();
		start_line();
		failures = 0;
	endfunction

	function void emit(logic kind, logic [2:0] idx, logic [15:0] value, logic [3:0] total,
			logic [5:0] chars, logic [1:0] st);
		res_t r;
		r.kind   = kind;
		r.code   = code;
		r.idx    = idx;
		r.value  = value;
		r.total  = total;
		r.chars  = chars;
		r.status = st;
		r.last   = 1'b0;
		awaited_results.push_back(r);
	endfunction

	function void emit_param();
		emit(KIND_PARAM, params_done[2:0], acc, 4'd0, 6'd0, ST_OK);
		params_done++;
		acc       = '0;
		in_number = 0;
	endfunction

	function void emit_end(int chars, logic [1:0] st);
		emit(KIND_END, 3'd0, 16'd0, params_done[3:0], chars[5:0], st);
	endfunction

	// Work out the results of one accepted byte; returns 1 if the byte was not ignored.
	function bit note_byte(logic [7:0] b);
		int queued_then;
		bit counted;
		queued_then = awaited_results.size();
		counted     = (b != CH_CR) && !dropping;
		if (b == CH_CR)
			return 0;
		if (b == CH_NL) begin
			if (!dropping) begin
				if (in_number)
					emit_param();
				emit_end(line_len, ST_OK);
			end
			start_line();
		end else if (dropping) begin
			return 0;
		end else if (line_len >= LINE_MAX - 1) begin
			emit_end(LINE_MAX - 1, ST_NO_TERM);
			dropping = 1;
		end else if (line_len == 0) begin
			code     = b;
			line_len = 1;
		end else begin
			line_len++;
			if (b == CH_SPACE) begin
				if (in_number)
					emit_param();
			end else if (b >= CH_ZERO && b <= CH_NINE) begin
				if (!in_number && params_done >= PARAM_MAX) begin
					emit_end(line_len, ST_TOO_MANY);
					dropping = 1;
				end else begin
					acc       = acc * 16'd10 + {8'h00, b - CH_ZERO};
					in_number = 1;
				end
			end else begin
				emit_end(line_len, ST_BAD_CHAR);
				dropping = 1;
			end
		end
		if (awaited_results.size() > queued_then)
			awaited_results[awaited_results.size() - 1].last = 1'b1;
		return counted;
	endfunction

	function string show(res_t r);
		return $sformatf("kind=%0d code=%02h idx=%0d value=%0d total=%0d chars=%0d status=%0d last=%0d",
			r.kind, r.code, r.idx, r.value, r.total, r.chars, r.status, r.last);
	endfunction

	function void report(string what);
		failures++;
		if (failures <= 10)
			$display("%s", what);
	endfunction

	function void check_result(res_t seen);
		res_t want;
		if (awaited_results.size() == 0) begin
			report({"unexpected result: ", show(seen)});
			return;
		end
		want = awaited_results.pop_front();
		if (seen.kind !== want.kind || seen.code !== want.code || seen.idx !== want.idx ||
				seen.value !== want.value || seen.total !== want.total ||
				seen.chars !== want.chars || seen.status !== want.status ||
				seen.last !== want.last)
			report({"mismatch: expected ", show(want), " got ", show(seen)});
	endfunction

	function void check_drained();
		if (awaited_results.size() != 0) begin
			$display("%0d results never arrived", awaited_results.size());
			failures += awaited_results.size();
		end
	endfunction

endclass

module command_line_decimal_parser_core_tb;

	localparam int MAX_LINE    = 64;
	localparam int MAX_PARAMS  = 8;
	localparam int ITEM_TARGET = 750;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic [7:0]  command_code;
	logic [2:0]  param_index;
	logic [15:0] param_value;
	logic [3:0]  param_total;
	logic [5:0]  char_count;
	logic [1:0]  status;
	logic        last;

	line_scoreboard #(MAX_LINE, MAX_PARAMS) sb;

	logic [7:0] line_bytes[$];
	int         items_sent;
	int         burst_left;
	int         rx_cycle;

	command_line_decimal_parser_core #(
		.MAX_LINE(MAX_LINE),
		.MAX_PARAMS(MAX_PARAMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.command_code(command_code),
		.param_index(param_index),
		.param_value(param_value),
		.param_total(param_total),
		.char_count(char_count),
		.status(status),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Take results; the stall pattern cycles through free-running, random,
	// periodic and long-hold stretches.
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if (out_valid && !out_stall)
				sb.check_result(res_t'({result_kind, command_code, param_index, param_value,
					param_total, char_count, status, last}));
			case ((rx_cycle / 97) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= (rx_cycle % 8) < 3;
				default: out_stall <= (rx_cycle % 61) < 9;
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		byte_in  <= b;
		do @(posedge clk); while (in_stall);
		items_sent += sb.note_byte(b);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
		end
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Hold the sender until every outstanding result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.awaited_results.size() != 0);
	endtask

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_other();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_NL || b == CH_CR || b == CH_SPACE || (b >= CH_ZERO && b <= CH_NINE));
		return b;
	endfunction

	function automatic void add_tail();
		logic [7:0] b;
		repeat ($urandom_range(0, 5)) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
			line_bytes.push_back(b);
		end
	endfunction

	function automatic void make_line();
		int pick;
		int n;
		string max_num;
		max_num = "65535";
		pick = $urandom_range(0, 99);
		line_bytes.delete();
		if (pick >= 94) begin
			repeat ($urandom_range(1, 10))
				line_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick >= 88) begin
			if ($urandom_range(0, 1))
				line_bytes.push_back(CH_CR);
			line_bytes.push_back(CH_NL);
		end else begin
			line_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(8'h41, 8'h5A)));
			if (pick < 60)
				n = $urandom_range(0, MAX_PARAMS);
			else if (pick < 70)
				n = MAX_PARAMS + $urandom_range(1, 2);
			else if (pick < 80)
				n = $urandom_range(0, MAX_PARAMS);
			else
				n = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) begin
				repeat ((i == 0 && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2))
					line_bytes.push_back(CH_SPACE);
				if ($urandom_range(0, 9) == 0)
					for (int k = 0; k < max_num.len(); k++)
						line_bytes.push_back(max_num[k]);
				else
					repeat ($urandom_range(1, pick < 70 ? 5 : 3))
						line_bytes.push_back(random_digit());
			end
			if (pick >= 70 && pick < 80) begin
				line_bytes.push_back(random_other());
				add_tail();
			end else if (pick >= 80) begin
				// run up to or past the line limit with long, wrapping numbers
				n = MAX_LINE - 1 + $urandom_range(0, 6);
				while (line_bytes.size() < n)
					line_bytes.push_back(($urandom_range(0, 15) == 0) ? CH_SPACE : random_digit());
				add_tail();
			end else begin
				repeat ($urandom_range(0, 2))
					line_bytes.push_back(CH_SPACE);
			end
			line_bytes.push_back(CH_NL);
		end
		if ($urandom_range(0, 4) == 0)
			line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CH_CR);
	endfunction

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		sb         = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		byte_in    = '0;
		out_stall  = 1'b0;
		items_sent = 0;
		burst_left = 0;
		rx_cycle   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty lines, spaces in every position, carriage returns, wrap, extremes and a bad character
		send_byte(CH_NL);
		send_byte(CH_CR);
		send_byte(CH_NL);
		send_byte(8'hFF);
		send_str("  65535 \r0 \n");
		send_byte(8'h00);
		send_str("65536\n");
		send_str("C12a9\r\n");
		wait_idle();

		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			make_line();
			foreach (line_bytes[i])
				send_byte(line_bytes[i]);
			if ($urandom_range(0, 49) == 0)
				wait_idle();
		end
		send_byte(CH_NL);

		wait_idle();
		repeat (32) @(posedge clk);
		sb.check_drained();
		if (sb.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
design/clp_pkg.sv
design/clp_front.sv
design/clp_queue.sv
design/clp_back.sv
design/command_line_decimal_parser_core.sv
sim/command_line_decimal_parser_core_tb.sv
